### src/stg_pkg.sv
// Package for the segmented triangle tone generator.
// Holds field widths, reset values, register codes and the request/result types.
// No dependencies.
package stg_pkg;

  localparam int unsigned SAMPLE_RATE_DEF = 44100;
  localparam int NSTAGE = 8;

  localparam int LEN_W = 24;
  localparam int TONE_W = 15;
  localparam int IDX_W = 26;
  localparam int SMP_W = 16;
  localparam int PHASE_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [LEN_W-1:0] FIRST_LENGTH_RST = 24'd26460;
  localparam logic [LEN_W-1:0] SECOND_LENGTH_RST = 24'd13230;
  localparam logic [LEN_W-1:0] THIRD_LENGTH_RST = 24'd26460;
  localparam logic [TONE_W-1:0] FIRST_TONE_RST = 15'd220;
  localparam logic [TONE_W-1:0] SECOND_TONE_RST = 15'd0;
  localparam logic [TONE_W-1:0] THIRD_TONE_RST = 15'd880;
  localparam logic [TONE_W-1:0] PEAK_LEVEL_RST = 15'd12000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_LENGTH,
    REG_SECOND_LENGTH,
    REG_THIRD_LENGTH,
    REG_FIRST_TONE,
    REG_SECOND_TONE,
    REG_THIRD_TONE,
    REG_PEAK_LEVEL
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] frame_index;
    logic             request_last;
  } frame_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    in_range;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]  first_length;
    logic [LEN_W-1:0]  second_length;
    logic [LEN_W-1:0]  third_length;
    logic [TONE_W-1:0] first_tone;
    logic [TONE_W-1:0] second_tone;
    logic [TONE_W-1:0] third_tone;
    logic [TONE_W-1:0] peak_level;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] local_pos;
    logic               live;
    logic               in_range;
    logic               last;
  } side_t;

endpackage

### src/stg_cfg.sv
// Configuration register file of the tone generator.
// Uses stg_pkg for register codes, widths and reset values.
module stg_cfg import stg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.first_length <= FIRST_LENGTH_RST;
      regs.second_length <= SECOND_LENGTH_RST;
      regs.third_length <= THIRD_LENGTH_RST;
      regs.first_tone <= FIRST_TONE_RST;
      regs.second_tone <= SECOND_TONE_RST;
      regs.third_tone <= THIRD_TONE_RST;
      regs.peak_level <= PEAK_LEVEL_RST;
    end else if (cfg_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIRST_LENGTH:  regs.first_length <= cfg_data[LEN_W-1:0];
        REG_SECOND_LENGTH: regs.second_length <= cfg_data[LEN_W-1:0];
        REG_THIRD_LENGTH:  regs.third_length <= cfg_data[LEN_W-1:0];
        REG_FIRST_TONE:    regs.first_tone <= cfg_data[TONE_W-1:0];
        REG_SECOND_TONE:   regs.second_tone <= cfg_data[TONE_W-1:0];
        REG_THIRD_TONE:    regs.third_tone <= cfg_data[TONE_W-1:0];
        REG_PEAK_LEVEL:    regs.peak_level <= cfg_data[TONE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/stg_seg.sv
// Segment locate stages: range check, segment pick, local frame position and tone.
// Uses stg_pkg; two register stages advanced by the enables from the top level.
module stg_seg import stg_pkg::*; (
  input  logic              clk,
  input  logic [1:0]        en,
  input  cfg_t              regs,
  input  frame_t            frame,
  output side_t             side,
  output logic [TONE_W-1:0] tone
);

  logic [IDX_W-1:0]   sum01;
  logic [IDX_W-1:0]   total;
  logic [IDX_W-1:0]   idx;
  logic               last;
  logic               in_range;
  logic               hit0;
  logic               hit1;
  logic [PHASE_W-1:0] base;

  assign sum01 = IDX_W'(regs.first_length) + IDX_W'(regs.second_length);
  assign total = sum01 + IDX_W'(regs.third_length);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      idx <= frame.frame_index;
      last <= frame.request_last;
      in_range <= frame.frame_index < total;
      hit0 <= frame.frame_index < IDX_W'(regs.first_length);
      hit1 <= frame.frame_index < sum01;
    end
  end

  always_comb begin
    if (hit0) begin
      base = '0;
    end else if (hit1) begin
      base = regs.first_length[PHASE_W-1:0];
    end else begin
      base = sum01[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side.local_pos <= idx[PHASE_W-1:0] - base;
      side.in_range <= in_range;
      side.last <= last;
      if (hit0) begin
        tone <= regs.first_tone;
        side.live <= in_range && (regs.first_tone != '0);
      end else if (hit1) begin
        tone <= regs.second_tone;
        side.live <= in_range && (regs.second_tone != '0);
      end else begin
        tone <= regs.third_tone;
        side.live <= in_range && (regs.third_tone != '0);
      end
    end
  end

endmodule

### src/stg_step.sv
// Phase step stages: floor(tone * 65536 / SAMPLE_RATE) by reciprocal multiply and
// one correction step. Uses stg_pkg; three register stages, side data carried along.
module stg_step import stg_pkg::*; #(
  parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
  input  logic               clk,
  input  logic [2:0]         en,
  input  side_t              side_in,
  input  logic [TONE_W-1:0]  tone,
  output side_t              side_out,
  output logic [PHASE_W-1:0] step
);

  localparam longint unsigned MAGIC = 64'd4294967296 / SAMPLE_RATE;
  localparam int MAG_W = $clog2(MAGIC + 1);
  localparam int RATE_W = $clog2(SAMPLE_RATE + 1);
  localparam int PW = TONE_W + MAG_W;
  localparam int QW = PW - PHASE_W;
  localparam int WIDE = QW + RATE_W;

  side_t             side3;
  side_t             side4;
  logic [TONE_W-1:0] tone3;
  logic [TONE_W-1:0] tone4;
  logic [PW-1:0]     prod;
  logic [QW-1:0]     qe;
  logic [WIDE-1:0]   qr;
  logic [WIDE-1:0]   num;
  logic [WIDE-1:0]   rem;
  logic              corr;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= PW'(tone) * PW'(MAG_W'(MAGIC));
      tone3 <= tone;
      side3 <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qe <= prod[PW-1:PHASE_W];
      qr <= WIDE'(prod[PW-1:PHASE_W]) * WIDE'(RATE_W'(SAMPLE_RATE));
      tone4 <= tone3;
      side4 <= side3;
    end
  end

  assign num = WIDE'({tone4, 16'h0000});
  assign rem = num - qr;
  assign corr = rem >= WIDE'(SAMPLE_RATE);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      step <= PHASE_W'({1'b0, qe} + (QW + 1)'(corr));
      side_out <= side4;
    end
  end

endmodule

### src/stg_wave.sv
// Wave stages: phase, triangle shape, amplitude scale and truncating divide by 32768.
// Uses stg_pkg; three register stages, the last one is the result register.
module stg_wave import stg_pkg::*; (
  input  logic               clk,
  input  logic [2:0]         en,
  input  side_t              side_in,
  input  logic [PHASE_W-1:0] step,
  input  logic [TONE_W-1:0]  peak_level,
  output result_t            result
);

  side_t                   side6;
  side_t                   side7;
  logic [PHASE_W-1:0]      phase;
  logic signed [16:0]      level;
  logic signed [31:0]      scaled;
  logic signed [31:0]      biased;
  logic signed [31:0]      quot;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      phase <= PHASE_W'(side_in.local_pos * step);
      side6 <= side_in;
    end
  end

  always_comb begin
    if (!phase[15]) begin
      level = $signed({2'b00, phase[14:0]} << 1) - 17'sd32768;
    end else begin
      level = 17'sd32767 - $signed({2'b00, phase[14:0]} << 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      scaled <= 32'(level) * 32'(signed'({1'b0, peak_level}));
      side7 <= side6;
    end
  end

  assign biased = scaled[31] ? scaled + 32'sd32767 : scaled;
  assign quot = biased >>> 15;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      result.sample <= side7.live ? quot[SMP_W-1:0] : '0;
      result.in_range <= side7.in_range;
      result.last <= side7.last;
    end
  end

endmodule

### src/segmented_triangle_tone_generator.sv
// Segmented triangle tone generator, top level.
// Frame requests enter on frame / frame_valid / frame_stall; one result per request
// leaves on result / result_valid / result_stall, in request order. A transfer
// happens on a clock edge with valid high and stall low on that channel.
// An accepted request passes the segment, step and wave stages; result_valid rises
// when it reaches the result register. Throughput is one request per cycle while
// result_stall is low, set by an 8-stage pipeline with at most one multiply per stage.
// Pipeline bubbles close up: frame_stall rises only when every stage is full
// and the result register is stalled, so requests keep entering while a result
// waits to be taken. A stall holds the result and loses nothing.
// Registers are written on cfg_en with cfg_index / cfg_data, no read-back;
// unknown indexes are ignored. Write them only while the pipeline is empty.
// Synchronous reset rst empties the pipeline and loads the default pattern:
// 26460 frames at 220 Hz, 13230 silent frames, 26460 frames at 880 Hz, level 12000.
// The sample is meant for both stereo channels.
module segmented_triangle_tone_generator import stg_pkg::*; #(
  parameter int unsigned SAMPLE_RATE = SAMPLE_RATE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  frame_valid,
  output logic                  frame_stall,
  input  frame_t                frame,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  cfg_t               regs;
  logic [NSTAGE-1:0]  vld;
  logic [NSTAGE-1:0]  en;
  side_t              side2;
  side_t              side5;
  logic [TONE_W-1:0]  tone2;
  logic [PHASE_W-1:0] step5;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || !result_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= frame_valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign frame_stall = !en[0];
  assign result_valid = vld[NSTAGE-1];

  stg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  stg_seg u_seg (
    .clk   (clk),
    .en    (en[1:0]),
    .regs  (regs),
    .frame (frame),
    .side  (side2),
    .tone  (tone2)
  );

  stg_step #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_step (
    .clk      (clk),
    .en       (en[4:2]),
    .side_in  (side2),
    .tone     (tone2),
    .side_out (side5),
    .step     (step5)
  );

  stg_wave u_wave (
    .clk        (clk),
    .en         (en[7:5]),
    .side_in    (side5),
    .step       (step5),
    .peak_level (regs.peak_level),
    .result     (result)
  );

`ifndef SYNTH
  a_out_of_range_silent: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.in_range |-> result.sample == '0)
    else $error("out-of-range result carries a nonzero sample");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> (vld == '1) && result_stall)
    else $error("request stalled while the pipeline has a bubble");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid && (vld == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

### bench/tb_segmented_triangle_tone_generator.sv
`timescale 1ns / 1ps
// Testbench for segmented_triangle_tone_generator: directed table, then random register phases.
// Predicts each result from its own copy of the registers or takes it from the directed table; uses types from stg_pkg.
module tb_segmented_triangle_tone_generator;
  import stg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int N_PHASE = 9;
  localparam int PER_PHASE = 126;
  localparam int QUIET_LIMIT = 2000;
  localparam longint IDX_MAX = (64'd1 << IDX_W) - 1;

  typedef struct {
    bit                    wr;
    logic [CFG_IDX_W-1:0]  sel;
    logic [CFG_DATA_W-1:0] data;
    frame_t                req;
    bit                    known;
    result_t               want;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  frame_valid;
  logic                  frame_stall;
  frame_t                frame;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;

  logic [LEN_W-1:0]  seg_len [3];
  logic [TONE_W-1:0] seg_hz [3];
  logic [TONE_W-1:0] peak;

  result_t   pending [$];
  plan_row_t plan [$];
  int        errors = 0;
  int        quiet = 0;
  bit        steady = 1'b0;

  segmented_triangle_tone_generator dut (
    .clk(clk),
    .rst(rst),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame(frame),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void model_write(input logic [CFG_IDX_W-1:0] sel,
                                      input logic [CFG_DATA_W-1:0] d);
    case (sel)
      REG_FIRST_LENGTH: seg_len[0] = d;
      REG_SECOND_LENGTH: seg_len[1] = d;
      REG_THIRD_LENGTH: seg_len[2] = d;
      REG_FIRST_TONE: seg_hz[0] = d[TONE_W-1:0];
      REG_SECOND_TONE: seg_hz[1] = d[TONE_W-1:0];
      REG_THIRD_TONE: seg_hz[2] = d[TONE_W-1:0];
      REG_PEAK_LEVEL: peak = d[TONE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pattern_total();
    return 32'(seg_len[0]) + 32'(seg_len[1]) + 32'(seg_len[2]);
  endfunction

  function automatic result_t tone_sample(input frame_t f);
    logic [31:0] idx, pos, step, phase, lim1;
    logic [TONE_W-1:0] hz;
    logic [15:0] q;
    int level;
    int scaled;
    result_t r;
    idx = 32'(f.frame_index);
    lim1 = 32'(seg_len[0]);
    r.last = f.request_last;
    r.in_range = 1'b1;
    scaled = 0;
    if (idx >= pattern_total()) begin
      r.in_range = 1'b0;
    end else begin
      if (idx < lim1) begin
        pos = idx;
        hz = seg_hz[0];
      end else if (idx < lim1 + 32'(seg_len[1])) begin
        pos = idx - lim1;
        hz = seg_hz[1];
      end else begin
        pos = idx - lim1 - 32'(seg_len[1]);
        hz = seg_hz[2];
      end
      if (hz != '0) begin
        step = 32'({hz, 16'h0000}) / 32'(SAMPLE_RATE_DEF);
        phase = pos * step;
        q = phase[15:0];
        if (!q[15]) level = -32768 + 2 * int'(q);
        else level = 32767 - 2 * (int'(q) - 32768);
        scaled = (level * int'(peak)) / 32768;
      end
    end
    r.sample = scaled[SMP_W-1:0];
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(3))
      0: return '0;
      3: return LEN_W'($urandom);
      default: return LEN_W'($urandom_range(3000, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_hz();
    case ($urandom_range(7))
      0: return '0;
      1: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(22050, 1));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_peak();
    case ($urandom_range(7))
      0: return '0;
      1: return CFG_DATA_W'(32767);
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(32767, 0));
    endcase
  endfunction

  function automatic frame_t rand_frame();
    longint pick;
    longint edge_pt;
    int r;
    frame_t f;
    r = $urandom_range(9);
    if (r < 6) begin
      pick = $urandom_range(pattern_total() + 8, 0);
    end else if (r < 8) begin
      case ($urandom_range(2))
        0: edge_pt = seg_len[0];
        1: edge_pt = longint'(seg_len[0]) + seg_len[1];
        default: edge_pt = pattern_total();
      endcase
      pick = edge_pt + $urandom_range(4) - 2;
    end else begin
      pick = $urandom & IDX_MAX;
    end
    if (pick < 0) pick = 0;
    if (pick > IDX_MAX) pick = IDX_MAX;
    f.frame_index = pick[IDX_W-1:0];
    f.request_last = ($urandom_range(3) == 0);
    return f;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] d);
    cfg_en <= 1'b1;
    cfg_index <= sel;
    cfg_data <= d;
    model_write(sel, d);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    frame_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_frame(input frame_t f, input result_t want);
    if (cfg_en) cfg_en <= 1'b0;
    while (!steady && $urandom_range(99) < 29) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame <= f;
    frame_valid <= 1'b1;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    pending.push_back(want);
    @(negedge clk);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] d);
    plan_row_t row;
    row = '{default: '0};
    row.wr = 1'b1;
    row.sel = sel;
    row.data = d;
    plan.push_back(row);
  endtask

  task automatic add_req(input longint idx, input bit last);
    plan_row_t row;
    row = '{default: '0};
    row.req.frame_index = idx[IDX_W-1:0];
    row.req.request_last = last;
    plan.push_back(row);
  endtask

  task automatic add_known(input longint idx, input bit last, input int smp, input bit inr);
    plan_row_t row;
    row = '{default: '0};
    row.req.frame_index = idx[IDX_W-1:0];
    row.req.request_last = last;
    row.known = 1'b1;
    row.want.sample = smp[SMP_W-1:0];
    row.want.in_range = inr;
    row.want.last = last;
    plan.push_back(row);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending.size() == 0) begin
      $error("unexpected result: sample %0d in_range %0b", got.sample, got.in_range);
      errors++;
    end else begin
      want = pending.pop_front();
      if (got.sample !== want.sample) begin
        $error("sample: expected %0d, got %0d", want.sample, got.sample);
        errors++;
      end
      if (got.in_range !== want.in_range) begin
        $error("in_range: expected %0b, got %0b", want.in_range, got.in_range);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    end
  endtask

  always @(negedge clk) begin
    result_stall <= !rst && !steady && ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (result_valid && !result_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ph;
    int n;
    frame_t f;
    logic [LEN_W-1:0] lv [3];
    logic [CFG_DATA_W-1:0] hv [3];
    logic [CFG_DATA_W-1:0] pk;

    rst = 1'b1;
    cfg_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_valid = 1'b0;
    frame = '0;
    seg_len[0] = FIRST_LENGTH_RST;
    seg_len[1] = SECOND_LENGTH_RST;
    seg_len[2] = THIRD_LENGTH_RST;
    seg_hz[0] = FIRST_TONE_RST;
    seg_hz[1] = SECOND_TONE_RST;
    seg_hz[2] = THIRD_TONE_RST;
    peak = PEAK_LEVEL_RST;

    add_known(0, 0, -12000, 1);
    add_req(26459, 0);
    add_known(26460, 0, 0, 1);
    add_known(39690, 1, -12000, 1);
    add_req(66149, 0);
    add_known(66150, 0, 0, 0);
    add_known(IDX_MAX, 1, 0, 0);
    add_req(12345, 1);
    add_write(REG_PEAK_LEVEL, 24'hFFFFFF);
    add_known(39690, 0, -32767, 1);
    add_req(39701, 0);
    add_write(REG_PEAK_LEVEL, 24'h0);
    add_known(100, 0, 0, 1);
    add_known(50000, 0, 0, 1);
    add_write(REG_PEAK_LEVEL, 24'd12000);
    add_write(REG_FIRST_LENGTH, 24'h0);
    add_known(0, 0, 0, 1);
    add_known(13230, 0, -12000, 1);
    add_write(REG_FIRST_TONE, 24'hFFFFFF);
    add_write(REG_FIRST_LENGTH, 24'hFFFFFF);
    add_req(1000, 0);
    add_req(24'hFFFFFE, 1);
    add_write(REG_SECOND_LENGTH, 24'hFFFFFF);
    add_write(REG_THIRD_LENGTH, 24'hFFFFFF);
    add_known(IDX_MAX, 1, 0, 0);
    add_req(50331644, 0);
    add_write(REG_SECOND_TONE, 24'd22050);
    add_write(REG_THIRD_TONE, 24'd1);
    add_known(16777215, 0, -12000, 1);
    add_req(16777300, 0);
    add_req(50331600, 1);
    add_write(REG_SPARE, 24'hFFFFFF);
    add_known(33554430, 0, -12000, 1);

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].wr) begin
        if (!cfg_en) wait_drained();
        write_reg(plan[i].sel, plan[i].data);
      end else if (plan[i].known) begin
        send_frame(plan[i].req, plan[i].want);
      end else begin
        send_frame(plan[i].req, tone_sample(plan[i].req));
      end
    end

    for (ph = 0; ph < N_PHASE; ph++) begin
      wait_drained();
      steady = (ph == 4);
      for (n = 0; n < 3; n++) begin
        lv[n] = (ph == 0) ? '1 : (ph == 1) ? '0 : rand_len();
        hv[n] = (ph == 0) ? '1 : rand_hz();
      end
      pk = (ph == 0) ? '1 : rand_peak();
      write_reg(REG_FIRST_LENGTH, lv[0]);
      write_reg(REG_SECOND_LENGTH, lv[1]);
      write_reg(REG_THIRD_LENGTH, lv[2]);
      write_reg(REG_FIRST_TONE, hv[0]);
      write_reg(REG_SECOND_TONE, hv[1]);
      write_reg(REG_THIRD_TONE, hv[2]);
      write_reg(REG_PEAK_LEVEL, pk);
      write_reg(REG_SPARE, CFG_DATA_W'($urandom));
      for (n = 0; n < PER_PHASE; n++) begin
        if (ph == 2 && n == PER_PHASE / 2) wait_drained();
        f = rand_frame();
        send_frame(f, tone_sample(f));
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (NSTAGE + 4) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
